/* design/sv32pte_pkg.sv */
package sv32pte_pkg;

  // Request codes
  typedef enum logic [1:0] {
    REQ_QUERY = 2'd0,
    REQ_MAP4K = 2'd1,
    REQ_UNMAP = 2'd2,
    REQ_MAP4M = 2'd3
  } req_type_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNMAPPED   = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_CONFLICT   = 3'd3,
    ST_NOTABLE    = 3'd4
  } status_t;

  localparam int unsigned ENTRY_W   = 32;
  localparam int unsigned VPN_W     = 10;
  localparam int unsigned PPN_W     = 20;
  localparam int unsigned ENTRIES   = 1024;

  // Fixed entry bits on every written leaf: V, A, D
  localparam logic [7:0] ENT_VAD    = 8'hC1;
  localparam logic [7:0] ENT_U      = 8'h10;
  // R, W, X, U, A, D mask kept when a superpage is split
  localparam logic [7:0] ENT_KEEP   = 8'hDE;
  localparam logic [7:0] ENT_V      = 8'h01;

  // Classified request passed from the front to the back
  typedef struct packed {
    req_type_t          req;
    logic               misaligned;
    logic [31:0]        va;
    logic [PPN_W-1:0]   pa_ppn;
    logic [3:0]         flags;
  } cmd_t;

  // Back status seen by the front
  typedef struct packed {
    logic clearing;
  } bk_stat_t;

  // Build a leaf entry from a physical page number and low bits
  function automatic logic [ENTRY_W-1:0] make_entry(input logic [PPN_W-1:0] ppn,
                                                    input logic [7:0] bits);
    make_entry = {2'b00, ppn, 2'b00, bits | ENT_VAD};
  endfunction

endpackage

/* design/sv32pte_if.sv */
interface sv32pte_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] virt_addr;
  logic [31:0] phys_addr_in;
  logic [3:0]  perm_flags;

  modport source (output valid, req_type, virt_addr, phys_addr_in, perm_flags, input ready);
  modport sink   (input valid, req_type, virt_addr, phys_addr_in, perm_flags, output ready);
  modport monitor (input valid, ready, req_type, virt_addr, phys_addr_in, perm_flags);
endinterface

interface sv32pte_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] phys_addr;
  logic [3:0]  perm_bits;

  modport source (output valid, status, phys_addr, perm_bits, input ready);
  modport sink   (input valid, status, phys_addr, perm_bits, output ready);
  modport monitor (input valid, ready, status, phys_addr, perm_bits);
endinterface

/* design/sv32pte_front.sv */
module sv32pte_front (
  sv32pte_in_if.sink              in_chan,
  input  sv32pte_pkg::bk_stat_t   bk_stat,
  input  logic                    q_full,
  output logic                    q_push,
  output sv32pte_pkg::cmd_t       q_cmd
);
  import sv32pte_pkg::*;

  req_type_t req;
  logic      va_4k, pa_4k, va_4m, pa_4m;

  // Take requests only when the queue has room and the root clear is done
  assign in_chan.ready = !q_full && !bk_stat.clearing;
  assign q_push        = in_chan.valid && in_chan.ready;

  // Classify alignment per request type
  assign req   = req_type_t'(in_chan.req_type);
  assign va_4k = |in_chan.virt_addr[11:0];
  assign pa_4k = |in_chan.phys_addr_in[11:0];
  assign va_4m = |in_chan.virt_addr[21:0];
  assign pa_4m = |in_chan.phys_addr_in[21:0];

  always_comb begin
    q_cmd.req    = req;
    q_cmd.va     = in_chan.virt_addr;
    q_cmd.pa_ppn = in_chan.phys_addr_in[31:12];
    q_cmd.flags  = in_chan.perm_flags;
    case (req)
      REQ_QUERY: q_cmd.misaligned = 1'b0;
      REQ_MAP4K: q_cmd.misaligned = va_4k || pa_4k;
      REQ_UNMAP: q_cmd.misaligned = va_4k;
      REQ_MAP4M: q_cmd.misaligned = va_4m || pa_4m;
      default:   q_cmd.misaligned = 1'b0;
    endcase
  end

endmodule

/* design/sv32pte_queue.sv */
module sv32pte_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sv32pte_pkg::cmd_t   push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output sv32pte_pkg::cmd_t   head_cmd
);
  import sv32pte_pkg::*;

  cmd_t       slot_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_cmd   = slot_r[rptr_r];

  // Hold payload slots
  always_ff @(posedge clk) begin
    if (push) slot_r[wptr_r] <= push_cmd;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* design/sv32pte_back.sv */
module sv32pte_back #(
  parameter int unsigned LEAF_TABLES = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    head_valid,
  input  sv32pte_pkg::cmd_t       head_cmd,
  output logic                    pop,
  output sv32pte_pkg::bk_stat_t   bk_stat,
  sv32pte_out_if.source           out_chan
);
  import sv32pte_pkg::*;

  localparam int unsigned TW    = (LEAF_TABLES > 1) ? $clog2(LEAF_TABLES) : 1;
  localparam int unsigned UW    = $clog2(LEAF_TABLES + 1);
  localparam int unsigned LAW   = TW + VPN_W;
  localparam int unsigned LDEPTH = LEAF_TABLES * ENTRIES;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ROOT, S_LEAF, S_FILL, S_LINK, S_RESP
  } state_t;

  // Memories
  logic [ENTRY_W-1:0] root_mem [ENTRIES];
  logic [ENTRY_W-1:0] leaf_mem [LDEPTH];

  logic               root_we, root_re;
  logic [VPN_W-1:0]   root_wa, root_ra;
  logic [ENTRY_W-1:0] root_wd, root_q_r;
  logic               leaf_we, leaf_re;
  logic [LAW-1:0]     leaf_wa, leaf_ra;
  logic [ENTRY_W-1:0] leaf_wd, leaf_q_r;

  // Control and result registers
  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [VPN_W-1:0]   cnt_r, cnt_nxt;
  logic [UW-1:0]      used_r, used_nxt;
  logic [TW-1:0]      idx_r, idx_nxt;
  logic               split_r, split_nxt;
  logic [ENTRY_W-1:0] e1_r, e1_nxt;
  logic [2:0]         res_st_r, res_st_nxt;
  logic [31:0]        res_pa_r, res_pa_nxt;
  logic [3:0]         res_perm_r, res_perm_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_st_r, out_st_nxt;
  logic [31:0]        out_pa_r, out_pa_nxt;
  logic [3:0]         out_perm_r, out_perm_nxt;

  logic [ENTRY_W-1:0] e1, e0;
  logic               e1_v, e1_rwx, ptr_ok, is_ptr, is_super, pool_full;
  logic [VPN_W-1:0]   vpn1, vpn0;
  logic [LAW-1:0]     leaf_addr;
  logic [ENTRY_W-1:0] new_leaf;

  assign bk_stat.clearing = (state_r == S_CLEAR);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_st_r;
  assign out_chan.phys_addr = out_pa_r;
  assign out_chan.perm_bits = out_perm_r;

  // Root entry classification
  assign e1        = root_q_r;
  assign e0        = leaf_q_r;
  assign e1_v      = e1[0];
  assign e1_rwx    = |e1[3:1];
  assign ptr_ok    = e1[31:10] < 22'(used_r);
  assign is_super  = e1_v && e1_rwx;
  assign is_ptr    = e1_v && !e1_rwx && ptr_ok;
  assign pool_full = (used_r == UW'(LEAF_TABLES));
  assign vpn1      = cmd_r.va[31:22];
  assign vpn0      = cmd_r.va[21:12];
  assign leaf_addr = {e1[TW+9:10], vpn0};
  assign new_leaf  = make_entry(cmd_r.pa_ppn, {4'b0000, cmd_r.flags[2:0], 1'b0} | ENT_U);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    cnt_nxt       = cnt_r;
    used_nxt      = used_r;
    idx_nxt       = idx_r;
    split_nxt     = split_r;
    e1_nxt        = e1_r;
    res_st_nxt    = res_st_r;
    res_pa_nxt    = res_pa_r;
    res_perm_nxt  = res_perm_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_st_nxt    = out_st_r;
    out_pa_nxt    = out_pa_r;
    out_perm_nxt  = out_perm_r;
    pop     = 1'b0;
    root_we = 1'b0;
    root_wa = vpn1;
    root_wd = '0;
    root_re = 1'b0;
    root_ra = head_cmd.va[31:22];
    leaf_we = 1'b0;
    leaf_wa = leaf_addr;
    leaf_wd = '0;
    leaf_re = 1'b0;
    leaf_ra = leaf_addr;

    case (state_r)
      // Zero the root table one entry a cycle
      S_CLEAR: begin
        root_we = 1'b1;
        root_wa = cnt_r;
        cnt_nxt = cnt_r + 1'b1;
        if (&cnt_r) state_nxt = S_IDLE;
      end
      // Pop the next request and read its root entry
      S_IDLE: begin
        if (head_valid) begin
          pop       = 1'b1;
          root_re   = 1'b1;
          cmd_nxt   = head_cmd;
          state_nxt = S_ROOT;
        end
      end
      // Act on the root entry
      S_ROOT: begin
        res_st_nxt   = ST_OK;
        res_pa_nxt   = '0;
        res_perm_nxt = '0;
        state_nxt    = S_RESP;
        if (cmd_r.misaligned) begin
          res_st_nxt = ST_MISALIGNED;
        end else begin
          case (cmd_r.req)
            REQ_QUERY: begin
              if (is_super) begin
                res_pa_nxt   = {e1[29:10], 12'h000} | {10'h000, cmd_r.va[21:0]};
                res_perm_nxt = e1[4:1];
              end else if (is_ptr) begin
                leaf_re   = 1'b1;
                state_nxt = S_LEAF;
              end else begin
                res_st_nxt = ST_UNMAPPED;
              end
            end
            REQ_MAP4K: begin
              if (is_ptr) begin
                leaf_we = 1'b1;
                leaf_wd = new_leaf;
              end else if (pool_full) begin
                res_st_nxt = ST_NOTABLE;
              end else begin
                idx_nxt   = TW'(used_r);
                used_nxt  = used_r + 1'b1;
                split_nxt = is_super;
                e1_nxt    = e1;
                cnt_nxt   = '0;
                state_nxt = S_FILL;
              end
            end
            REQ_UNMAP: begin
              if (is_super) begin
                res_st_nxt = ST_CONFLICT;
              end else if (is_ptr) begin
                leaf_we = 1'b1;
              end
            end
            REQ_MAP4M: begin
              root_we = 1'b1;
              root_wd = make_entry(cmd_r.pa_ppn, {3'b000, cmd_r.flags, 1'b0});
            end
            default: res_st_nxt = ST_OK;
          endcase
        end
      end
      // Check the leaf entry of a query
      S_LEAF: begin
        if (e0[0] && (|e0[3:1])) begin
          res_pa_nxt   = {e0[29:10], cmd_r.va[11:0]};
          res_perm_nxt = e0[4:1];
        end else begin
          res_st_nxt = ST_UNMAPPED;
        end
        state_nxt = S_RESP;
      end
      // Fill a new leaf table, zero or split from the superpage
      S_FILL: begin
        leaf_we = 1'b1;
        leaf_wa = {idx_r, cnt_r};
        leaf_wd = split_r ? make_entry({e1_r[29:20], cnt_r}, e1_r[7:0] & ENT_KEEP) : '0;
        cnt_nxt = cnt_r + 1'b1;
        if (&cnt_r) state_nxt = S_LINK;
      end
      // Point the root at the new table and write the mapped entry
      S_LINK: begin
        root_we   = 1'b1;
        root_wd   = {22'(idx_r), 2'b00, ENT_V};
        leaf_we   = 1'b1;
        leaf_wa   = {idx_r, vpn0};
        leaf_wd   = new_leaf;
        state_nxt = S_RESP;
      end
      // Hand the result to the output register
      S_RESP: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_pa_nxt    = res_pa_r;
          out_perm_nxt  = res_perm_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    split_r    <= split_nxt;
    e1_r       <= e1_nxt;
    res_st_r   <= res_st_nxt;
    res_pa_r   <= res_pa_nxt;
    res_perm_r <= res_perm_nxt;
    out_st_r   <= out_st_nxt;
    out_pa_r   <= out_pa_nxt;
    out_perm_r <= out_perm_nxt;
  end

  // Root table memory
  always_ff @(posedge clk) begin
    if (root_we) root_mem[root_wa] <= root_wd;
    if (root_re) root_q_r <= root_mem[root_ra];
  end

  // Leaf pool memory
  always_ff @(posedge clk) begin
    if (leaf_we) leaf_mem[leaf_wa] <= leaf_wd;
    if (leaf_re) leaf_q_r <= leaf_mem[leaf_ra];
  end

endmodule

/* design/sv32_page_table_engine.sv */
// Channel    Dir   Payload
// in_chan    in    req_type, virt_addr, phys_addr_in, perm_flags
// out_chan   out   status, phys_addr, perm_bits
//
// Most requests go from transfer to result through queue pop, root read, result and
// output register; a query through a leaf table adds a leaf read.
// A 4K map that allocates a table fills it first: the leaf fill writes
// one entry a cycle through the single leaf pool write port.
// After reset the root table is zeroed with in_chan.ready low.
// A two-entry queue sits between intake and the table sequencer; a stalled
// output holds the sequencer in its result step.
module sv32_page_table_engine #(
  parameter int unsigned LEAF_TABLES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  sv32pte_in_if.sink     in_chan,
  sv32pte_out_if.source  out_chan
);
  import sv32pte_pkg::*;

  logic     q_push, q_full, q_pop, head_valid;
  cmd_t     q_cmd, head_cmd;
  bk_stat_t bk_stat;

  sv32pte_front u_front (
    .in_chan (in_chan),
    .bk_stat (bk_stat),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  sv32pte_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  sv32pte_back #(
    .LEAF_TABLES (LEAF_TABLES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .bk_stat    (bk_stat),
    .out_chan   (out_chan)
  );

endmodule

/* bench/sv32pte_bench_if.sv */
// Bench copy of the channel interfaces is not needed: the design interfaces are used.
// This file holds the shared bench constants.
package sv32pte_bench_pkg;
  localparam int unsigned POOL_TABLES = 16;
  localparam int unsigned STALL_LIMIT = 20000;
endpackage

/* bench/sv32pte_scoreboard.sv */
module sv32pte_scoreboard (
  input  logic            clk,
  input  logic            rst_n,
  sv32pte_in_if.monitor   in_mon,
  sv32pte_out_if.monitor  out_mon,
  output int              fail_count,
  output int              pending,
  output int              seen_results
);
  import sv32pte_pkg::*;
  import sv32pte_bench_pkg::*;

  typedef struct packed {
    status_t     st;
    logic [31:0] pa;
    logic [3:0]  perm;
  } xlate_t;

  logic [31:0] root_tbl [ENTRIES];
  logic [31:0] leaf_tbl [POOL_TABLES*ENTRIES];
  int unsigned tables_alloc;
  xlate_t      xlate_q[$];

  // 0 invalid or dangling pointer, 1 superpage, 2 live pointer
  function automatic int classify(input logic [31:0] e);
    if (!e[0]) return 0;
    if (|e[3:1]) return 1;
    if (e[31:10] >= tables_alloc) return 0;
    return 2;
  endfunction

  task automatic walk_request(input req_type_t rq, input logic [31:0] va,
                              input logic [31:0] pa, input logic [3:0] fl);
    int unsigned v1, v0, kind, tix, i;
    logic [31:0] e1, e0, pbase;
    xlate_t r;
    v1 = va[31:22];
    v0 = va[21:12];
    e1 = root_tbl[v1];
    kind = classify(e1);
    r = '{ST_OK, 32'd0, 4'd0};
    case (rq)
      REQ_QUERY: begin
        if (kind == 0) r.st = ST_UNMAPPED;
        else if (kind == 1) begin
          r.pa = {e1[29:10], 12'd0} | {10'd0, va[21:0]};
          r.perm = e1[4:1];
        end else begin
          e0 = leaf_tbl[e1[31:10]*ENTRIES + v0];
          if (!e0[0] || !(|e0[3:1])) r.st = ST_UNMAPPED;
          else begin
            r.pa = {e0[29:10], 12'd0} | {20'd0, va[11:0]};
            r.perm = e0[4:1];
          end
        end
      end
      REQ_MAP4K: begin
        if (va[11:0] != 0 || pa[11:0] != 0) r.st = ST_MISALIGNED;
        else if (kind != 2 && tables_alloc >= POOL_TABLES) r.st = ST_NOTABLE;
        else begin
          if (kind == 2) tix = e1[31:10];
          else begin
            tix = tables_alloc;
            tables_alloc++;
            pbase = {e1[29:10], 12'd0} & 32'hffc0_0000;
            for (i = 0; i < ENTRIES; i++)
              leaf_tbl[tix*ENTRIES + i] = (kind == 1) ?
                {2'b00, pbase[31:12] + i[19:0], 2'b00, (e1[7:0] & ENT_KEEP) | ENT_VAD} :
                32'd0;
            root_tbl[v1] = {tix[21:0], 10'd0} | 32'(ENT_V);
          end
          leaf_tbl[tix*ENTRIES + v0] =
            {2'b00, pa[31:12], 2'b00, {3'b000, 1'b1, fl[2:0], 1'b0} | ENT_VAD};
        end
      end
      REQ_UNMAP: begin
        if (va[11:0] != 0) r.st = ST_MISALIGNED;
        else if (kind == 1) r.st = ST_CONFLICT;
        else if (kind == 2) leaf_tbl[e1[31:10]*ENTRIES + v0] = 32'd0;
      end
      default: begin
        if (va[21:0] != 0 || pa[21:0] != 0) r.st = ST_MISALIGNED;
        else root_tbl[v1] = {2'b00, pa[31:12], 2'b00, {3'b000, fl, 1'b0} | ENT_VAD};
      end
    endcase
    xlate_q.push_back(r);
  endtask

  xlate_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) root_tbl[i] = 32'd0;
      tables_alloc = 0;
      xlate_q.delete();
      fail_count = 0;
      seen_results = 0;
    end else begin
      // check result transfer before predicting the new request
      if (out_mon.valid && out_mon.ready) begin
        seen_results++;
        if (xlate_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d pa=%h perm=%h", $time,
                   out_mon.status, out_mon.phys_addr, out_mon.perm_bits);
          fail_count++;
        end else begin
          want = xlate_q.pop_front();
          if (out_mon.status !== want.st || out_mon.phys_addr !== want.pa ||
              out_mon.perm_bits !== want.perm) begin
            $display("%0t: expected status=%0d pa=%h perm=%h, got status=%0d pa=%h perm=%h",
                     $time, want.st, want.pa, want.perm,
                     out_mon.status, out_mon.phys_addr, out_mon.perm_bits);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        walk_request(req_type_t'(in_mon.req_type), in_mon.virt_addr,
                     in_mon.phys_addr_in, in_mon.perm_flags);
    end
    pending = xlate_q.size();
  end
endmodule

/* bench/sv32_page_table_engine_test.sv */
module sv32_page_table_engine_test;
  import sv32pte_pkg::*;
  import sv32pte_bench_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending, seen_results;
  int   idle_cycles = 0;
  int   sent = 0;
  bit   stim_done = 0;
  bit   long_hold = 0;
  int   drain;

  sv32pte_in_if  in_chan();
  sv32pte_out_if out_chan();

  sv32_page_table_engine #(.LEAF_TABLES(POOL_TABLES)) DUT (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source));

  sv32pte_scoreboard checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan.monitor), .out_mon(out_chan.monitor),
    .fail_count(fail_count), .pending(pending), .seen_results(seen_results));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.req_type = REQ_QUERY;
    in_chan.virt_addr = '0;
    in_chan.phys_addr_in = '0;
    in_chan.perm_flags = '0;
    out_chan.ready = 1'b0;
  end

  // one request: wait, offer, hold until transfer
  task automatic send_req(input req_type_t rq, input logic [31:0] va,
                          input logic [31:0] pa, input logic [3:0] fl);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid <= 1'b1;
    in_chan.req_type <= rq;
    in_chan.virt_addr <= va;
    in_chan.phys_addr_in <= pa;
    in_chan.perm_flags <= fl;
    do @(posedge clk); while (!in_chan.ready);
    sent++;
  endtask

  // addresses aligned as asked, mostly drawn from superpage slots 0 to 23 and pages 0 to 7 for reuse
  function automatic logic [31:0] pick_va(input int align);
    logic [31:0] v;
    v = $urandom();
    if ($urandom_range(0, 9) < 8) v[31:22] = 10'($urandom_range(0, 23));
    if ($urandom_range(0, 9) < 8) v[21:12] = 10'($urandom_range(0, 7));
    if (align >= 12) v[11:0] = '0;
    if (align >= 22) v[21:0] = '0;
    return v;
  endfunction

  // receiver: random wait per result, one long hold-off
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_chan.ready <= 1'b0;
        repeat (200) @(negedge clk);
        long_hold = 0;
      end
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // watchdog on lack of progress
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || !rst_n)
      idle_cycles <= 0;
    else if (pending != 0 || !stim_done)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [31:0] va, pa;
    int kind;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, each request kind, each special case but pool exhaustion
    send_req(REQ_QUERY, 32'hffff_ffff, 32'hffff_ffff, 4'hf);
    send_req(REQ_UNMAP, 32'h0000_1000, '0, '0);
    send_req(REQ_UNMAP, 32'h0000_1001, '0, '0);
    send_req(REQ_MAP4K, 32'h0000_1001, 32'h0000_1000, 4'h1);
    send_req(REQ_MAP4K, 32'h0000_1000, 32'h0000_1800, 4'h1);
    send_req(REQ_MAP4K, 32'h0000_1000, 32'hffff_f000, 4'h0);
    send_req(REQ_QUERY, 32'h0000_1abc, '0, '0);
    send_req(REQ_MAP4K, 32'h0000_2000, 32'h1234_5000, 4'h2);
    send_req(REQ_QUERY, 32'h0000_2fff, '0, '0);
    send_req(REQ_UNMAP, 32'h0000_1000, '0, '0);
    send_req(REQ_QUERY, 32'h0000_1000, '0, '0);
    send_req(REQ_MAP4M, 32'hffc0_0000, 32'hffc0_0000, 4'hf);
    send_req(REQ_QUERY, 32'hffff_ffff, '0, '0);
    send_req(REQ_MAP4M, 32'h0040_0000, 32'h0020_0000, 4'h3);
    send_req(REQ_MAP4M, 32'h0040_0000, 32'h8000_0000, 4'h9);
    send_req(REQ_UNMAP, 32'h0040_5000, '0, '0);
    send_req(REQ_MAP4K, 32'h0040_5000, 32'h0000_0000, 4'h4);
    send_req(REQ_QUERY, 32'h0040_6123, '0, '0);
    send_req(REQ_QUERY, 32'h0040_5123, '0, '0);
    // pointer-shaped superpage: live index, then a dangling one
    send_req(REQ_MAP4M, 32'h0080_0000, 32'h0000_0000, 4'h8);
    send_req(REQ_QUERY, 32'h0080_1000, '0, '0);
    send_req(REQ_MAP4M, 32'h00c0_0000, 32'h0fc0_0000, 4'h0);
    send_req(REQ_QUERY, 32'h00c0_0000, '0, '0);
    send_req(REQ_UNMAP, 32'h00c0_0000, '0, '0);
    send_req(REQ_MAP4K, 32'h00c0_0000, 32'h0000_3000, 4'h7);

    // random: mostly aligned maps and lookups in a busy region
    for (int n = 0; n < 1700; n++) begin
      if (n == 600) long_hold = 1;
      kind = $urandom_range(0, 99);
      pa = $urandom();
      if (kind < 40) begin
        va = pick_va(0);
        send_req(REQ_QUERY, va, pa, 4'($urandom_range(0, 15)));
      end else if (kind < 60) begin
        va = pick_va($urandom_range(0, 9) ? 12 : 0);
        if ($urandom_range(0, 9)) pa[11:0] = '0;
        send_req(REQ_MAP4K, va, pa, 4'($urandom_range(0, 15)));
      end else if (kind < 78) begin
        va = pick_va($urandom_range(0, 9) ? 12 : 0);
        send_req(REQ_UNMAP, va, pa, 4'($urandom_range(0, 15)));
      end else begin
        va = pick_va($urandom_range(0, 5) ? 22 : 0);
        if ($urandom_range(0, 5)) pa[21:0] = '0;
        if ($urandom_range(0, 9) == 0) pa = {10'($urandom_range(0, 20)), 22'd0};
        send_req(REQ_MAP4M, va, pa, 4'($urandom_range(0, 15)));
      end
    end
    @(negedge clk);
    in_chan.valid <= 1'b0;
    stim_done = 1;

    wait (pending == 0);
    drain = 0;
    while (drain < 40) begin
      @(posedge clk);
      drain++;
    end
    $display("Sent %0d requests of all four kinds, %0d results checked,", sent, seen_results);
    $display("covering superpage splits, dangling pointers, misalignment and pool exhaustion.");
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
